// File: sv/gsmf_pkg.sv
package gsmf_pkg;

  localparam int MAX_WINDOW     = 25;
  localparam int IDX_W          = $clog2(MAX_WINDOW);
  localparam int CNT_W          = $clog2(MAX_WINDOW + 1);
  localparam int MM_W           = 13;
  localparam int RAW_W          = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 13;
  localparam int WINDOW_W       = 5;

  localparam logic [RAW_W-1:0]    SENSOR_LIMIT_MM = RAW_W'(8000);
  localparam logic [WINDOW_W-1:0] WINDOW_LIMIT    = WINDOW_W'(25);
  localparam logic [WINDOW_W-1:0] WINDOW_DEFAULT  = WINDOW_W'(5);
  localparam logic [MM_W-1:0]     MAX_MM_RESET    = MM_W'(8000);

  localparam logic [CFG_IDX_W-1:0] REG_ENABLED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_MM  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_MM  = 2'd3;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OFF       = 2'd1,
    ST_READ_FAIL = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DROP,
    B_INSERT,
    B_MEDIAN,
    B_DONE
  } back_state_e;

  typedef struct packed {
    status_e         status;
    logic [MM_W-1:0] mm;
  } item_t;

  typedef struct packed {
    status_e         status;
    logic [MM_W-1:0] raw_mm;
    logic [MM_W-1:0] filtered_mm;
    logic            valid_res;
  } result_t;

  // gating settings seen by the classifier
  typedef struct packed {
    logic            enabled;
    logic [MM_W-1:0] min_mm;
    logic [MM_W-1:0] max_mm;
  } gate_cfg_t;

endpackage

// File: sv/gsmf_front.sv
module gsmf_front (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        distance_mm_i,
  input  logic               read_ok_i,
  input  gsmf_pkg::gate_cfg_t cfg_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output gsmf_pkg::item_t    push_item_o
);
  import gsmf_pkg::*;

  logic in_range;

  assign in_range = (distance_mm_i != '0) && (distance_mm_i < SENSOR_LIMIT_MM)
                 && (distance_mm_i >= RAW_W'(cfg_i.min_mm))
                 && (distance_mm_i <= RAW_W'(cfg_i.max_mm));

  always_comb begin
    push_item_o.mm = '0;
    if (!cfg_i.enabled) begin
      push_item_o.status = ST_OFF;
    end else if (!read_ok_i) begin
      push_item_o.status = ST_READ_FAIL;
    end else if (!in_range) begin
      push_item_o.status = ST_RANGE;
    end else begin
      push_item_o.status = ST_OK;
      push_item_o.mm     = distance_mm_i[MM_W-1:0];
    end
  end

  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

endmodule

// File: sv/gsmf_queue.sv
module gsmf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  gsmf_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output gsmf_pkg::item_t pop_item_o
);
  import gsmf_pkg::*;

  item_t      slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_item_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// File: sv/gsmf_back.sv
module gsmf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [4:0]        window_length_i,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  gsmf_pkg::item_t   pop_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gsmf_pkg::result_t out_res_o
);
  import gsmf_pkg::*;

  back_state_e state_q, state_d;

  item_t             item_q;
  logic [MM_W-1:0]   med_q;
  logic [MM_W-1:0]   hist_q   [MAX_WINDOW];
  logic [MM_W-1:0]   sorted_q [MAX_WINDOW];
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [IDX_W-1:0]  oldest_q, oldest_d;
  logic              out_valid_q;
  result_t           out_res_q;

  logic [WINDOW_W-1:0] win;
  logic                need_drop;
  logic [IDX_W:0]      wr_sum;
  logic [IDX_W-1:0]    wr_addr;
  logic [MM_W-1:0]     old_val;
  logic [MAX_WINDOW-1:0] ge_old, gt_new;
  logic                out_free;

  logic take, drop_en, ins_en, med_en, load_out;

  assign win       = (window_length_i == '0 || window_length_i > WINDOW_LIMIT)
                     ? WINDOW_DEFAULT : window_length_i;
  assign need_drop = (fill_q >= CNT_W'(win)) && (fill_q != '0);
  assign out_free  = !out_valid_q || out_ready_i;

  // ring slot after the newest entry
  assign wr_sum  = (IDX_W+1)'(oldest_q) + (IDX_W+1)'(fill_q);
  assign wr_addr = (wr_sum >= (IDX_W+1)'(MAX_WINDOW))
                   ? IDX_W'(wr_sum - (IDX_W+1)'(MAX_WINDOW)) : wr_sum[IDX_W-1:0];
  assign old_val = hist_q[oldest_q];

  // both masks are monotone over the sorted row
  always_comb begin
    for (int j = 0; j < MAX_WINDOW; j++) begin
      ge_old[j] = sorted_q[j] >= old_val;
      gt_new[j] = (CNT_W'(j) >= fill_q) || (sorted_q[j] > item_q.mm);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (pop_valid_i) begin
          state_d = (pop_item_i.status == ST_OK) ? B_DROP : B_DONE;
        end
      end
      B_DROP: begin
        if (!need_drop) begin
          state_d = B_INSERT;
        end
      end
      B_INSERT: state_d = B_MEDIAN;
      B_MEDIAN: state_d = B_DONE;
      B_DONE: begin
        if (out_free) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    take     = 1'b0;
    drop_en  = 1'b0;
    ins_en   = 1'b0;
    med_en   = 1'b0;
    load_out = 1'b0;
    case (state_q)
      B_IDLE:   take     = 1'b1;
      B_DROP:   drop_en  = need_drop;
      B_INSERT: ins_en   = 1'b1;
      B_MEDIAN: med_en   = 1'b1;
      B_DONE:   load_out = out_free;
      default: ;
    endcase
  end

  assign pop_ready_o = take;

  always_comb begin
    fill_d   = fill_q;
    oldest_d = oldest_q;
    if (drop_en) begin
      fill_d   = fill_q - CNT_W'(1);
      oldest_d = (oldest_q == IDX_W'(MAX_WINDOW - 1)) ? '0 : oldest_q + IDX_W'(1);
    end else if (ins_en) begin
      fill_d = fill_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      fill_q      <= '0;
      oldest_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      oldest_q <= oldest_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && pop_valid_i) begin
      item_q <= pop_item_i;
    end
    if (ins_en) begin
      hist_q[wr_addr] <= item_q.mm;
    end
    if (med_en) begin
      med_q <= sorted_q[{1'b0, fill_q[CNT_W-1:1]}];
    end
    if (load_out) begin
      out_res_q.status      <= item_q.status;
      out_res_q.raw_mm      <= item_q.mm;
      out_res_q.filtered_mm <= (item_q.status == ST_OK) ? med_q : '0;
      out_res_q.valid_res   <= (item_q.status == ST_OK);
    end
  end

  // sorted row: remove the oldest word, then insert the new one
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < MAX_WINDOW; j++) begin
      if (drop_en) begin
        if (j < MAX_WINDOW - 1 && ge_old[j]) begin
          sorted_q[j] <= sorted_q[(j < MAX_WINDOW - 1) ? j + 1 : j];
        end
      end else if (ins_en) begin
        if (gt_new[j]) begin
          if (j > 0 && gt_new[(j > 0) ? j - 1 : j]) begin
            sorted_q[j] <= sorted_q[(j > 0) ? j - 1 : j];
          end else begin
            sorted_q[j] <= item_q.mm;
          end
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

// File: sv/gated_sliding_median_range_filter.sv
// channel  | direction | handshake                  | payload
// in       | input     | in_valid_i / in_ready_o    | distance_mm_i, read_ok_i
// out      | output    | out_valid_o / out_ready_i  | status_o, raw_mm_o, filtered_mm_o,
//          |           |                            | valid_res_o
// cfg      | input     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// A rejected word goes from idle straight to done in the back end; an accepted one passes through
// drop (fill - window + 1 history entries dropped when full), insert, median and done, in that order.
// The sequencer in the back end handles one word at a time; the 2-word queue
// lets the input side keep accepting while a result waits on out_ready_i.
// Reset clears the config and control registers, the queue and the history fill; no clearing pass.
// cfg_ready_o is always high.
module gated_sliding_median_range_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] distance_mm_i,
  input  logic        read_ok_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [12:0] raw_mm_o,
  output logic [12:0] filtered_mm_o,
  output logic        valid_res_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i
);
  import gsmf_pkg::*;

  logic                enabled_q;
  logic [WINDOW_W-1:0] window_q;
  logic [MM_W-1:0]     min_mm_q;
  logic [MM_W-1:0]     max_mm_q;

  gate_cfg_t gate_cfg;
  item_t     push_item, pop_item;
  logic      push_valid, push_ready, pop_valid, pop_ready;
  result_t   res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      window_q  <= WINDOW_DEFAULT;
      min_mm_q  <= '0;
      max_mm_q  <= MAX_MM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ENABLED: enabled_q <= cfg_data_i[0];
        REG_WINDOW:  window_q  <= cfg_data_i[WINDOW_W-1:0];
        REG_MIN_MM:  min_mm_q  <= cfg_data_i[MM_W-1:0];
        REG_MAX_MM:  max_mm_q  <= cfg_data_i[MM_W-1:0];
        default: ;
      endcase
    end
  end

  assign gate_cfg.enabled = enabled_q;
  assign gate_cfg.min_mm  = min_mm_q;
  assign gate_cfg.max_mm  = max_mm_q;

  gsmf_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .distance_mm_i (distance_mm_i),
    .read_ok_i     (read_ok_i),
    .cfg_i         (gate_cfg),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_item_o   (push_item)
  );

  gsmf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  gsmf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .window_length_i (window_q),
    .pop_valid_i     (pop_valid),
    .pop_ready_o     (pop_ready),
    .pop_item_i      (pop_item),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_res_o       (res)
  );

  assign status_o      = res.status;
  assign raw_mm_o      = res.raw_mm;
  assign filtered_mm_o = res.filtered_mm;
  assign valid_res_o   = res.valid_res;

endmodule
